### design/ssat_pkg.sv
package ssat_pkg;

  // result kinds
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_ARG_END = 2'd1;
  localparam logic [1:0] KIND_CMD_END = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_SQUOTE    = 2'd1;
  localparam logic [1:0] ERR_DQUOTE    = 2'd2;
  localparam logic [1:0] ERR_UNEXP_END = 2'd3;

  // most results one item can cause: four utf-8 bytes, one text byte, one error
  localparam int unsigned RES_MAX = 6;
  localparam int unsigned CNT_W   = 3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [1:0] error_code;
    logic       out_last;
  } out_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rbyte;
    logic [1:0] err;
  } res_t;

  // all results of one item, queued between front and back
  typedef struct packed {
    res_t [RES_MAX-1:0] item;
    logic [CNT_W-1:0]   cnt;
  } rec_t;

endpackage

### design/ssat_front.sv
module ssat_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ssat_pkg::in_t in_data_i,
  input  logic          q_full_i,
  output logic          push_o,
  output ssat_pkg::rec_t push_data_o
);
  import ssat_pkg::*;

  typedef enum logic [8:0] {
    M_BETWEEN = 9'b000000001,
    M_ARG     = 9'b000000010,
    M_BSL     = 9'b000000100,
    M_SQ      = 9'b000001000,
    M_DQ      = 9'b000010000,
    M_DQ_BSL  = 9'b000100000,
    M_DQ_X1   = 9'b001000000,
    M_DQ_X2   = 9'b010000000,
    M_DQ_U    = 9'b100000000
  } mode_e;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  mode_e       mode_q, mode_d;
  logic [31:0] cp_q, cp_d, cpn;
  logic [3:0]  dl_q, dl_d;
  logic [3:0]  fh_q, fh_d;

  logic [7:0]  c;
  logic [4:0]  hv;
  logic        hok;
  logic        accept, fin;
  logic        do_arg, do_emit, do_dqp;
  res_t [RES_MAX-1:0] res;
  logic [CNT_W-1:0]   n;

  function automatic logic [4:0] hexval(input logic [7:0] b);
    logic [4:0] v;
    v = 5'd16;
    if (b >= 8'h30 && b <= 8'h39) v = 5'(b - 8'h30);
    else if (b >= 8'h61 && b <= 8'h66) v = 5'(b - 8'h57);
    else if (b >= 8'h41 && b <= 8'h46) v = 5'(b - 8'h37);
    return v;
  endfunction

  function automatic res_t mk(input logic [1:0] k, input logic [7:0] b, input logic [1:0] e);
    res_t r;
    r.kind  = k;
    r.rbyte = b;
    r.err   = e;
    return r;
  endfunction

  assign c      = in_data_i.in_byte;
  assign hv     = hexval(c);
  assign hok    = ~hv[4];
  assign accept = in_valid_i & ~q_full_i;
  assign fin    = (c == 8'h00) | in_data_i.in_last;

  always_comb begin
    mode_d  = mode_q;
    cp_d    = cp_q;
    dl_d    = dl_q;
    fh_d    = fh_q;
    cpn     = cp_q;
    do_arg  = 1'b0;
    do_emit = 1'b0;
    do_dqp  = 1'b0;
    res     = '0;
    n       = '0;

    if (c != 8'h00) begin
      case (mode_q)
        M_BETWEEN: begin
          if (c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D)) begin
            mode_d = M_BETWEEN;
          end else if (c == CH_SEMI) begin
            res[n] = mk(KIND_CMD_END, 8'h00, ERR_NONE);
            n = n + 3'd1;
          end else begin
            mode_d = M_ARG;
            do_arg = 1'b1;
          end
        end
        M_ARG: do_arg = 1'b1;
        M_BSL: begin
          res[n] = mk(KIND_DATA, c, ERR_NONE);
          n = n + 3'd1;
          mode_d = M_ARG;
        end
        M_SQ: begin
          if (c == CH_SQ) begin
            mode_d = M_ARG;
          end else begin
            res[n] = mk(KIND_DATA, c, ERR_NONE);
            n = n + 3'd1;
          end
        end
        M_DQ: do_dqp = 1'b1;
        M_DQ_BSL: begin
          mode_d = M_DQ;
          case (c)
            8'h61: begin res[n] = mk(KIND_DATA, 8'd7, ERR_NONE); n = n + 3'd1; end
            8'h62: begin res[n] = mk(KIND_DATA, 8'd8, ERR_NONE); n = n + 3'd1; end
            8'h66: begin res[n] = mk(KIND_DATA, 8'd12, ERR_NONE); n = n + 3'd1; end
            8'h6E: begin res[n] = mk(KIND_DATA, 8'd10, ERR_NONE); n = n + 3'd1; end
            8'h72: begin res[n] = mk(KIND_DATA, 8'd13, ERR_NONE); n = n + 3'd1; end
            8'h74: begin res[n] = mk(KIND_DATA, 8'd9, ERR_NONE); n = n + 3'd1; end
            8'h76: begin res[n] = mk(KIND_DATA, 8'd11, ERR_NONE); n = n + 3'd1; end
            CH_BSL, CH_DQ: begin
              res[n] = mk(KIND_DATA, c, ERR_NONE);
              n = n + 3'd1;
            end
            8'h78: mode_d = M_DQ_X1;
            8'h75: begin
              cp_d   = '0;
              dl_d   = 4'd4;
              mode_d = M_DQ_U;
            end
            8'h55: begin
              cp_d   = '0;
              dl_d   = 4'd8;
              mode_d = M_DQ_U;
            end
            default: begin
              // unknown escape keeps its backslash
              res[n] = mk(KIND_DATA, CH_BSL, ERR_NONE);
              n = n + 3'd1;
              res[n] = mk(KIND_DATA, c, ERR_NONE);
              n = n + 3'd1;
            end
          endcase
        end
        M_DQ_X1: begin
          if (hok) begin
            fh_d   = hv[3:0];
            mode_d = M_DQ_X2;
          end else begin
            mode_d = M_DQ;
            do_dqp = 1'b1;
          end
        end
        M_DQ_X2: begin
          mode_d = M_DQ;
          if (hok) begin
            res[n] = mk(KIND_DATA, {fh_q, hv[3:0]}, ERR_NONE);
            n = n + 3'd1;
          end else begin
            do_dqp = 1'b1;
          end
        end
        M_DQ_U: begin
          if (hok) begin
            cpn  = {cp_q[27:0], hv[3:0]};
            cp_d = cpn;
            if (dl_q <= 4'd1) begin
              dl_d    = '0;
              do_emit = 1'b1;
              mode_d  = M_DQ;
            end else begin
              dl_d = dl_q - 4'd1;
            end
          end else begin
            dl_d    = '0;
            do_emit = 1'b1;
            mode_d  = M_DQ;
            do_dqp  = 1'b1;
          end
        end
        default: mode_d = M_BETWEEN;
      endcase
    end

    // unquoted byte inside an argument
    if (do_arg) begin
      case (c)
        CH_SPACE, CH_TAB, CH_LF, CH_CR: begin
          res[n] = mk(KIND_ARG_END, 8'h00, ERR_NONE);
          n = n + 3'd1;
          mode_d = M_BETWEEN;
        end
        CH_SEMI: begin
          res[n] = mk(KIND_ARG_END, 8'h00, ERR_NONE);
          n = n + 3'd1;
          res[n] = mk(KIND_CMD_END, 8'h00, ERR_NONE);
          n = n + 3'd1;
          mode_d = M_BETWEEN;
        end
        CH_SQ:  mode_d = M_SQ;
        CH_DQ:  mode_d = M_DQ;
        CH_BSL: mode_d = M_BSL;
        default: begin
          res[n] = mk(KIND_DATA, c, ERR_NONE);
          n = n + 3'd1;
        end
      endcase
    end

    // code point out as utf-8, dropped above the unicode range
    if (do_emit && cpn <= 32'h0010FFFF) begin
      if (cpn < 32'h80) begin
        res[n] = mk(KIND_DATA, cpn[7:0], ERR_NONE);
        n = n + 3'd1;
      end else if (cpn < 32'h800) begin
        res[n] = mk(KIND_DATA, {3'b110, cpn[10:6]}, ERR_NONE);
        n = n + 3'd1;
        res[n] = mk(KIND_DATA, {2'b10, cpn[5:0]}, ERR_NONE);
        n = n + 3'd1;
      end else if (cpn < 32'h10000) begin
        res[n] = mk(KIND_DATA, {4'b1110, cpn[15:12]}, ERR_NONE);
        n = n + 3'd1;
        res[n] = mk(KIND_DATA, {2'b10, cpn[11:6]}, ERR_NONE);
        n = n + 3'd1;
        res[n] = mk(KIND_DATA, {2'b10, cpn[5:0]}, ERR_NONE);
        n = n + 3'd1;
      end else begin
        res[n] = mk(KIND_DATA, {5'b11110, cpn[20:18]}, ERR_NONE);
        n = n + 3'd1;
        res[n] = mk(KIND_DATA, {2'b10, cpn[17:12]}, ERR_NONE);
        n = n + 3'd1;
        res[n] = mk(KIND_DATA, {2'b10, cpn[11:6]}, ERR_NONE);
        n = n + 3'd1;
        res[n] = mk(KIND_DATA, {2'b10, cpn[5:0]}, ERR_NONE);
        n = n + 3'd1;
      end
    end

    // plain double-quoted text
    if (do_dqp) begin
      if (c == CH_DQ) begin
        mode_d = M_ARG;
      end else if (c == CH_BSL) begin
        mode_d = M_DQ_BSL;
      end else begin
        res[n] = mk(KIND_DATA, c, ERR_NONE);
        n = n + 3'd1;
      end
    end

    // end of string
    if (fin) begin
      case (mode_d)
        M_BETWEEN: begin
          res[n] = mk(KIND_CMD_END, 8'h00, ERR_NONE);
          n = n + 3'd1;
        end
        M_ARG: begin
          res[n] = mk(KIND_ARG_END, 8'h00, ERR_NONE);
          n = n + 3'd1;
          res[n] = mk(KIND_CMD_END, 8'h00, ERR_NONE);
          n = n + 3'd1;
        end
        M_SQ: begin
          res[n] = mk(KIND_ERROR, 8'h00, ERR_SQUOTE);
          n = n + 3'd1;
        end
        M_BSL, M_DQ_BSL: begin
          res[n] = mk(KIND_ERROR, 8'h00, ERR_UNEXP_END);
          n = n + 3'd1;
        end
        default: begin
          res[n] = mk(KIND_ERROR, 8'h00, ERR_DQUOTE);
          n = n + 3'd1;
        end
      endcase
      mode_d = M_BETWEEN;
      cp_d   = '0;
      dl_d   = '0;
      fh_d   = '0;
    end
  end

  assign in_stall_o       = q_full_i;
  assign push_o           = accept & (n != '0);
  assign push_data_o.item = res;
  assign push_data_o.cnt  = n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_BETWEEN;
      cp_q   <= '0;
      dl_q   <= '0;
      fh_q   <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      cp_q   <= cp_d;
      dl_q   <= dl_d;
      fh_q   <= fh_d;
    end
  end

endmodule

### design/ssat_queue.sv
module ssat_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ssat_pkg::rec_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output ssat_pkg::rec_t pop_data_o
);
  import ssat_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rec_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & ~empty_o;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### design/ssat_back.sv
module ssat_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  ssat_pkg::rec_t q_data_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ssat_pkg::out_t out_data_o
);
  import ssat_pkg::*;

  rec_t             hold_q;
  logic [CNT_W-1:0] idx_q;
  logic             valid_q;
  logic             is_last, take, done, need;
  res_t             cur;

  assign cur     = hold_q.item[idx_q];
  assign is_last = (idx_q == hold_q.cnt - 3'd1);
  assign take    = valid_q & ~out_stall_i;
  assign done    = take & is_last;
  assign need    = ~valid_q | done;
  assign pop_o   = need & ~q_empty_i;

  assign out_valid_o           = valid_q;
  assign out_data_o.kind       = cur.kind;
  assign out_data_o.out_byte   = cur.rbyte;
  assign out_data_o.error_code = cur.err;
  assign out_data_o.out_last   = is_last;

  always_ff @(posedge clk_i) begin
    if (pop_o) hold_q <= q_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (done) begin
      valid_q <= 1'b0;
    end else if (take) begin
      idx_q <= idx_q + 3'd1;
    end
  end

endmodule

### design/shell_style_argument_tokenizer_unit.sv
// shell-style argument tokenizer
// input channel: one command-text byte per item (in_byte, in_last); a zero
//   byte ends the string unprocessed, in_last ends it after the byte
// output channel: one result per item: data byte, argument end, command end
//   or error (unclosed single or double quote, dangling backslash);
//   out_last marks the final result caused by one input byte
// both channels use valid/stall; an item moves when valid is high and stall low
// the first result of a byte goes through a queue entry and then the back's
//   single result register before out_valid rises
// throughput: one input byte per cycle while each byte gives at most one
//   result and out_stall is low; a byte giving more results (utf-8 from \u
//   or \U, up to six with an error) holds later ones back in the queue
// the front decodes a byte combinationally and pushes all its results as one
//   entry into a QDepth-entry queue; the back plays results out one per cycle
// a stall on the output fills the queue; input stall rises only when full
// reset returns the decoder to between-arguments and empties queue and output
module shell_style_argument_tokenizer_unit #(
  parameter int unsigned QDepth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ssat_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ssat_pkg::out_t out_data_o
);
  import ssat_pkg::*;

  // front to queue
  logic push, q_full;
  rec_t push_data;
  // queue to back
  logic pop, q_empty;
  rec_t pop_data;

  ssat_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  ssat_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .pop_data_o  (pop_data)
  );

  ssat_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### bench/testbench.sv
module testbench;
  import ssat_pkg::*;

  // byte values the tokenizer treats specially
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_LOW_U = 8'h75;
  localparam logic [7:0] CH_UP_U  = 8'h55;

  // cycles without any handshake before the run is declared hung; the slowest
  // legal stretch is the long output hold-off plus a heavy stall phase
  localparam int WATCHDOG_LIMIT = 2000;
  // quiet cycles after the last expected token, to catch stray results
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_ITEMS   = 330;
  localparam int HOLD_CYCLES    = 60;
  localparam int HOLD_AFTER     = 120;

  // expected token stream of the tokenizer, fed with every accepted byte
  class tokenizer_scoreboard;
    typedef enum logic [3:0] {
      ST_BETWEEN, ST_ARG, ST_BSL, ST_SQ, ST_DQ, ST_DQ_BSL, ST_DQ_X1, ST_DQ_X2, ST_DQ_U
    } scan_state_e;

    scan_state_e scan_state;
    logic        in_word;
    logic [31:0] code_acc;
    logic [3:0]  digits_left;
    logic [3:0]  high_nibble;
    out_t        step_tokens[$];
    out_t        pending_tokens[$];
    int          failures;

    function new();
      failures = 0;
      clear_state();
    endfunction

    function void clear_state();
      scan_state  = ST_BETWEEN;
      in_word     = 1'b0;
      code_acc    = '0;
      digits_left = '0;
      high_nibble = '0;
    endfunction

    function void add_token(logic [1:0] kind, logic [7:0] b, logic [1:0] err);
      out_t t;
      t.kind       = kind;
      t.out_byte   = b;
      t.error_code = err;
      t.out_last   = 1'b0;
      step_tokens.push_back(t);
    endfunction

    function logic [4:0] hex_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
      if (c >= "a" && c <= "f") return 5'(c - 8'h57);
      if (c >= "A" && c <= "F") return 5'(c - 8'h37);
      return 5'd16;
    endfunction

    function void utf8_out(logic [31:0] u);
      if (u > 32'h10FFFF) return;
      if (u < 32'h80) begin
        add_token(KIND_DATA, u[7:0], ERR_NONE);
      end else if (u < 32'h800) begin
        add_token(KIND_DATA, {3'b110, u[10:6]}, ERR_NONE);
        add_token(KIND_DATA, {2'b10, u[5:0]}, ERR_NONE);
      end else if (u < 32'h10000) begin
        add_token(KIND_DATA, {4'b1110, u[15:12]}, ERR_NONE);
        add_token(KIND_DATA, {2'b10, u[11:6]}, ERR_NONE);
        add_token(KIND_DATA, {2'b10, u[5:0]}, ERR_NONE);
      end else begin
        add_token(KIND_DATA, {5'b11110, u[20:18]}, ERR_NONE);
        add_token(KIND_DATA, {2'b10, u[17:12]}, ERR_NONE);
        add_token(KIND_DATA, {2'b10, u[11:6]}, ERR_NONE);
        add_token(KIND_DATA, {2'b10, u[5:0]}, ERR_NONE);
      end
    endfunction

    function void dq_text(logic [7:0] c);
      if (c == CH_DQ) scan_state = ST_ARG;
      else if (c == CH_BSL) scan_state = ST_DQ_BSL;
      else add_token(KIND_DATA, c, ERR_NONE);
    endfunction

    function void dq_escape(logic [7:0] c);
      scan_state = ST_DQ;
      case (c)
        "a": add_token(KIND_DATA, 8'd7, ERR_NONE);
        "b": add_token(KIND_DATA, 8'd8, ERR_NONE);
        "f": add_token(KIND_DATA, 8'd12, ERR_NONE);
        "n": add_token(KIND_DATA, 8'd10, ERR_NONE);
        "r": add_token(KIND_DATA, 8'd13, ERR_NONE);
        "t": add_token(KIND_DATA, 8'd9, ERR_NONE);
        "v": add_token(KIND_DATA, 8'd11, ERR_NONE);
        CH_BSL, CH_DQ: add_token(KIND_DATA, c, ERR_NONE);
        CH_LOW_X: scan_state = ST_DQ_X1;
        CH_LOW_U: begin
          code_acc = '0; digits_left = 4'd4; scan_state = ST_DQ_U;
        end
        CH_UP_U: begin
          code_acc = '0; digits_left = 4'd8; scan_state = ST_DQ_U;
        end
        default: begin
          // unknown escape keeps its backslash
          add_token(KIND_DATA, CH_BSL, ERR_NONE);
          add_token(KIND_DATA, c, ERR_NONE);
        end
      endcase
    endfunction

    function void word_byte(logic [7:0] c);
      case (c)
        CH_SPACE, 8'h09, 8'h0A, 8'h0D: begin
          add_token(KIND_ARG_END, CH_NUL, ERR_NONE);
          in_word = 1'b0;
          scan_state = ST_BETWEEN;
        end
        CH_SEMI: begin
          add_token(KIND_ARG_END, CH_NUL, ERR_NONE);
          add_token(KIND_CMD_END, CH_NUL, ERR_NONE);
          in_word = 1'b0;
          scan_state = ST_BETWEEN;
        end
        CH_SQ:  scan_state = ST_SQ;
        CH_DQ:  scan_state = ST_DQ;
        CH_BSL: scan_state = ST_BSL;
        default: add_token(KIND_DATA, c, ERR_NONE);
      endcase
    endfunction

    function void scan_byte(logic [7:0] c);
      logic [4:0] h;
      h = hex_of(c);
      case (scan_state)
        ST_BETWEEN: begin
          // blanks between words are skipped, a bare ';' is an empty command
          if (c == CH_SEMI) begin
            add_token(KIND_CMD_END, CH_NUL, ERR_NONE);
          end else if (c != CH_SPACE && (c < 8'd9 || c > 8'd13)) begin
            in_word = 1'b1;
            scan_state = ST_ARG;
            word_byte(c);
          end
        end
        ST_ARG: word_byte(c);
        ST_BSL: begin
          add_token(KIND_DATA, c, ERR_NONE);
          scan_state = ST_ARG;
        end
        ST_SQ: begin
          if (c == CH_SQ) scan_state = ST_ARG;
          else add_token(KIND_DATA, c, ERR_NONE);
        end
        ST_DQ:     dq_text(c);
        ST_DQ_BSL: dq_escape(c);
        ST_DQ_X1: begin
          if (h < 5'd16) begin
            high_nibble = h[3:0];
            scan_state = ST_DQ_X2;
          end else begin
            scan_state = ST_DQ;
            dq_text(c);
          end
        end
        ST_DQ_X2: begin
          scan_state = ST_DQ;
          if (h < 5'd16) add_token(KIND_DATA, {high_nibble, h[3:0]}, ERR_NONE);
          else dq_text(c);
        end
        ST_DQ_U: begin
          if (h < 5'd16) begin
            code_acc = (code_acc << 4) | 32'(h[3:0]);
            if (digits_left <= 4'd1) begin
              digits_left = '0;
              utf8_out(code_acc);
              scan_state = ST_DQ;
            end else begin
              digits_left = digits_left - 4'd1;
            end
          end else begin
            // short escape: value so far goes out, the byte is plain text
            digits_left = '0;
            utf8_out(code_acc);
            scan_state = ST_DQ;
            dq_text(c);
          end
        end
        default: begin
          scan_state = ST_BETWEEN;
          in_word = 1'b0;
        end
      endcase
    endfunction

    function void end_of_string();
      case (scan_state)
        ST_BETWEEN: add_token(KIND_CMD_END, CH_NUL, ERR_NONE);
        ST_ARG: begin
          add_token(KIND_ARG_END, CH_NUL, ERR_NONE);
          add_token(KIND_CMD_END, CH_NUL, ERR_NONE);
        end
        ST_SQ:             add_token(KIND_ERROR, CH_NUL, ERR_SQUOTE);
        ST_BSL, ST_DQ_BSL: add_token(KIND_ERROR, CH_NUL, ERR_UNEXP_END);
        default:           add_token(KIND_ERROR, CH_NUL, ERR_DQUOTE);
      endcase
    endfunction

    function void note_input(in_t item);
      out_t t;
      step_tokens.delete();
      if (item.in_byte != CH_NUL) scan_byte(item.in_byte);
      if (item.in_byte == CH_NUL || item.in_last) begin
        end_of_string();
        clear_state();
      end
      if (step_tokens.size() > 0) begin
        t = step_tokens.pop_back();
        t.out_last = 1'b1;
        step_tokens.push_back(t);
      end
      foreach (step_tokens[k]) pending_tokens.push_back(step_tokens[k]);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_tokens.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected token: kind %0d byte %02h err %0d last %0d",
                   got.kind, got.out_byte, got.error_code, got.out_last);
        return;
      end
      want = pending_tokens.pop_front();
      if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
          got.error_code !== want.error_code || got.out_last !== want.out_last) begin
        failures++;
        if (failures <= 10)
          $display({"token mismatch: expected kind %0d byte %02h err %0d last %0d,",
                    " got kind %0d byte %02h err %0d last %0d"},
                   want.kind, want.out_byte, want.error_code, want.out_last,
                   got.kind, got.out_byte, got.error_code, got.out_last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  tokenizer_scoreboard sb;
  in_t text_q[$];          // command text bytes still to be offered
  int  idle_cycles = 0;    // cycles since the last handshake on either side
  int  bytes_taken = 0;
  bit  hold_active = 1'b0; // receiver is in its long hold-off
  bit  hold_done = 1'b0;
  bit  timed_out = 1'b0;

  always #5 clk = ~clk;

  shell_style_argument_tokenizer_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // both handshakes are sampled at the edge, before any nonblocking update
  // lands, so the values seen are the ones the block saw
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_input(in_data);
        bytes_taken++;
      end
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // ---------------------------------------------------------------------
  // command text generation
  // ---------------------------------------------------------------------
  function automatic void push_byte(logic [7:0] c, logic last);
    in_t item;
    item.in_byte = c;
    item.in_last = last;
    text_q.push_back(item);
  endfunction

  function automatic void push_text(string s);
    for (int k = 0; k < s.len(); k++) push_byte(s[k], k == s.len() - 1);
  endfunction

  function automatic logic [7:0] any_nonzero();
    return 8'($urandom_range(1, 255));
  endfunction

  // printable byte with no quoting meaning; '$' and '~' are included
  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126));
    while (c == CH_SQ || c == CH_DQ || c == CH_BSL || c == CH_SEMI);
    return c;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  // \u or \U escape, mostly full length, sometimes cut short
  function automatic void gen_unicode(bit wide);
    logic [31:0] v;
    int ndig;
    int k;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 'h7F);
      1: v = $urandom_range('h80, 'h7FF);
      2: v = $urandom_range('h800, 'hFFFF);
      3: v = $urandom_range('h10000, 'h10FFFF);
      4: v = $urandom;
      default: v = wide ? 32'h10FFFF + $urandom_range(0, 1) : 32'hFFFF;
    endcase
    ndig = wide ? 8 : 4;
    if ($urandom_range(0, 2) == 0) ndig = $urandom_range(0, ndig);
    push_byte(CH_BSL, 1'b0);
    push_byte(wide ? CH_UP_U : CH_LOW_U, 1'b0);
    for (k = ndig - 1; k >= 0; k--) push_byte(hex_char(v[k*4 +: 4]), 1'b0);
  endfunction

  function automatic void gen_dq_part();
    logic [7:0] simple_esc [9] = '{"a", "b", "f", "n", "r", "t", "v", CH_BSL, CH_DQ};
    logic [7:0] c;
    int n;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        do c = any_nonzero(); while (c == CH_DQ || c == CH_BSL);
        push_byte(c, 1'b0);
      end
      3, 4: begin
        push_byte(CH_BSL, 1'b0);
        push_byte(simple_esc[$urandom_range(0, 8)], 1'b0);
      end
      5: begin
        // \x with zero, one or two hex digits
        push_byte(CH_BSL, 1'b0);
        push_byte(CH_LOW_X, 1'b0);
        n = $urandom_range(0, 2);
        repeat (n) push_byte(hex_char(4'($urandom_range(0, 15))), 1'b0);
      end
      6: gen_unicode(1'b0);
      7: gen_unicode(1'b1);
      8: begin
        push_byte(CH_BSL, 1'b0);
        push_byte(any_nonzero(), 1'b0);
      end
      default: push_byte(any_nonzero(), 1'b0);
    endcase
  endfunction

  // one command string: mostly well-formed words and quotes, some noise
  function automatic void gen_command();
    logic [7:0] blank_set [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    logic [7:0] c;
    in_t tail;
    int w;
    int n;
    repeat ($urandom_range(1, 8)) begin
      w = $urandom_range(0, 99);
      if (w < 12) begin
        push_byte(blank_set[$urandom_range(0, 5)], 1'b0);
      end else if (w < 18) begin
        push_byte(CH_SEMI, 1'b0);
      end else if (w < 40) begin
        n = $urandom_range(1, 4);
        repeat (n) push_byte(word_char(), 1'b0);
      end else if (w < 55) begin
        push_byte(CH_SQ, 1'b0);
        n = $urandom_range(0, 4);
        repeat (n) begin
          do c = any_nonzero(); while (c == CH_SQ);
          push_byte(c, 1'b0);
        end
        if ($urandom_range(0, 9) != 0) push_byte(CH_SQ, 1'b0);
      end else if (w < 85) begin
        push_byte(CH_DQ, 1'b0);
        n = $urandom_range(1, 4);
        repeat (n) gen_dq_part();
        if ($urandom_range(0, 9) != 0) push_byte(CH_DQ, 1'b0);
      end else if (w < 92) begin
        push_byte(CH_BSL, 1'b0);
        push_byte(any_nonzero(), 1'b0);
      end else begin
        push_byte(any_nonzero(), 1'b0);
      end
    end
    // end the string on its last byte, or with a terminating zero byte
    if ($urandom_range(0, 3) != 0) begin
      tail = text_q.pop_back();
      tail.in_last = 1'b1;
      text_q.push_back(tail);
    end else begin
      push_byte(CH_NUL, 1'($urandom_range(0, 1)));
    end
  endfunction

  // ---------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------
  // sender: bursts of back-to-back bytes with random gaps, no gaps while
  // the receiver holds off so the internal queue is sure to fill
  task automatic send_text();
    int burst;
    int gap;
    burst = 0;
    while (text_q.size() > 0) begin
      if (burst == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0 && !hold_active) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20);
      end
      in_valid <= 1'b1;
      in_data  <= text_q.pop_front();
      do @(posedge clk); while (in_stall);
      burst--;
    end
    in_valid <= 1'b0;
  endtask

  // receiver: phases of no stall, light, even and heavy stalling, plus one
  // long hold-off once enough bytes have gone in
  initial begin : receiver
    int phase;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!hold_done && bytes_taken >= HOLD_AFTER) begin
        hold_active = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
        hold_done = 1'b1;
      end else begin
        phase = $urandom_range(0, 3);
        repeat ($urandom_range(4, 40)) begin
          case (phase)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= 1'($urandom_range(0, 1));
            default: out_stall <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    sb = new();

    // directed strings: ';' between commands, escaped blank, ';' inside a
    // word, a full \U at the top code point left in an open double quote,
    // a dangling backslash, a lone zero byte, byte 0xff, an open single quote
    push_text(";a\\ b");
    push_text("\"\\U0010FFFF");
    push_text("\\");
    push_byte(CH_NUL, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_text("'x");
    push_text("c;");
    push_byte(CH_NUL, 1'b1);

    while (text_q.size() < RANDOM_ITEMS) gen_command();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    fork
      begin
        send_text();
        // the monitor notes the final byte at the edge the sender returns on
        @(posedge clk);
        while (sb.pending_tokens.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
      end
      begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        timed_out = 1'b1;
      end
    join_any

    if (!timed_out && sb.failures == 0 && sb.pending_tokens.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

### shell_style_argument_tokenizer_unit.f
design/ssat_pkg.sv
design/ssat_front.sv
design/ssat_queue.sv
design/ssat_back.sv
design/shell_style_argument_tokenizer_unit.sv
bench/testbench.sv
